>>> rtl/rcpe_pkg.sv
// Shared types and constants for the remote code pulse encoder.
// No dependencies; every other file in rtl/ imports this package.
package rcpe_pkg;

  localparam int CODE_W   = 24;  // width of the code_word field
  localparam int SYNC_W   = 6;   // sync header length registers
  localparam int PULSE_W  = 4;   // short/long pulse length registers
  localparam int TICK_W   = 6;   // phase tick counter
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Reset values of the timing registers
  localparam logic [SYNC_W-1:0]  SYNC_HIGH_RST = 6'd1;
  localparam logic [SYNC_W-1:0]  SYNC_LOW_RST  = 6'd31;
  localparam logic [PULSE_W-1:0] SHORT_RST     = 4'd1;
  localparam logic [PULSE_W-1:0] LONG_RST      = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_HIGH = 2'd0,
    REG_SYNC_LOW  = 2'd1,
    REG_SHORT     = 2'd2,
    REG_LONG      = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SYNC_HI = 3'd1,
    PH_SYNC_LO = 3'd2,
    PH_BIT_HI  = 3'd3,
    PH_BIT_LO  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [SYNC_W-1:0]  sync_high_ticks;
    logic [SYNC_W-1:0]  sync_low_ticks;
    logic [PULSE_W-1:0] short_ticks;
    logic [PULSE_W-1:0] long_ticks;
  } timing_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

>>> rtl/rcpe_if.sv
// Valid/ready channel interfaces: item input, result output, register writes.
// Depends on rcpe_pkg for field widths.
interface rcpe_item_if import rcpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CODE_W-1:0] code_word;
  modport source (output valid, command, code_word, input ready);
  modport sink   (input valid, command, code_word, output ready);
endinterface

interface rcpe_result_if import rcpe_pkg::*; ();
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;
  modport source (output valid, line_level, busy_res, frame_done, input ready);
  modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

interface rcpe_cfg_if import rcpe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rcpe_cfg_regs.sv
// Timing register file written through the configuration channel.
// Depends on rcpe_pkg.
module rcpe_cfg_regs import rcpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output timing_t               timing
);

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.sync_high_ticks <= SYNC_HIGH_RST;
      timing.sync_low_ticks  <= SYNC_LOW_RST;
      timing.short_ticks     <= SHORT_RST;
      timing.long_ticks      <= LONG_RST;
    end else if (wr_en) begin
      case (cfg_reg_e'(wr_index))
        REG_SYNC_HIGH: timing.sync_high_ticks <= wr_data[SYNC_W-1:0];
        REG_SYNC_LOW:  timing.sync_low_ticks  <= wr_data[SYNC_W-1:0];
        REG_SHORT:     timing.short_ticks     <= wr_data[PULSE_W-1:0];
        REG_LONG:      timing.long_ticks      <= wr_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rcpe_core.sv
// Frame sequencer: phase, tick counter, bit shifter; one transaction per cycle while step is high.
// Depends on rcpe_pkg.
module rcpe_core import rcpe_pkg::*; #(
  parameter int CODE_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,       // accepted item
  input  logic              command,
  input  logic [CODE_W-1:0] code_word,
  input  timing_t           timing,
  output result_t           result,     // result of the current item
  output logic              busy
);

  localparam int BL_W   = $clog2(CODE_BITS + 1);
  localparam int LOAD_W = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;

  phase_e                phase, phase_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [CODE_BITS-1:0]  shift_word, shift_word_next;
  logic [BL_W-1:0]       bits_left, bits_left_next;

  logic [LOAD_W-1:0]     load_ext;
  logic [TICK_W-1:0]     tick_inc;
  logic [TICK_W-1:0]     len;
  logic [PULSE_W-1:0]    hi_len, lo_len;
  logic                  top_bit;
  logic                  phase_end;
  logic                  level;

  assign load_ext = LOAD_W'(code_word);
  assign top_bit  = shift_word[CODE_BITS-1];
  assign hi_len   = top_bit ? timing.long_ticks  : timing.short_ticks;
  assign lo_len   = top_bit ? timing.short_ticks : timing.long_ticks;
  assign tick_inc = tick_count + TICK_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      shift_word <= '0;
      bits_left  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      shift_word <= shift_word_next;
      bits_left  <= bits_left_next;
    end
  end

  always_comb begin
    busy  = 1'b0;
    level = 1'b0;
    len   = TICK_W'(1);
    case (phase)
      PH_SYNC_HI: begin busy = 1'b1; level = 1'b1; len = timing.sync_high_ticks; end
      PH_SYNC_LO: begin busy = 1'b1; len = timing.sync_low_ticks; end
      PH_BIT_HI:  begin busy = 1'b1; level = 1'b1; len = TICK_W'(hi_len); end
      PH_BIT_LO:  begin busy = 1'b1; len = TICK_W'(lo_len); end
      default: ;
    endcase
  end

  // zero length behaves as one tick
  assign phase_end = (len == '0) || (tick_inc >= len);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    shift_word_next = shift_word;
    bits_left_next  = bits_left;
    result          = '0;
    if (command) begin
      if (!busy) begin
        shift_word_next = load_ext[CODE_BITS-1:0];
        bits_left_next  = BL_W'(CODE_BITS);
        phase_next      = PH_SYNC_HI;
        tick_count_next = '0;
        result.line_level = 1'b1;
      end else begin
        result.line_level = level;
      end
      result.busy_res = 1'b1;
    end else if (!busy) begin
      phase_next = PH_IDLE;
    end else begin
      result.line_level = level;
      result.busy_res   = 1'b1;
      tick_count_next   = tick_inc;
      if (phase_end) begin
        tick_count_next = '0;
        case (phase)
          PH_SYNC_HI: phase_next = PH_SYNC_LO;
          PH_SYNC_LO: phase_next = PH_BIT_HI;
          PH_BIT_HI:  phase_next = PH_BIT_LO;
          default: begin
            shift_word_next = shift_word << 1;
            bits_left_next  = (bits_left != '0) ? bits_left - BL_W'(1) : '0;
            if (bits_left_next == '0) begin
              phase_next        = PH_IDLE;
              result.frame_done = 1'b1;
            end else begin
              phase_next = PH_BIT_HI;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/rcpe_out_buf.sv
// Two-entry result register with skid slot; decouples input ready from output stall.
// Depends on rcpe_pkg.
module rcpe_out_buf import rcpe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    pop_valid,
  input  logic    pop,
  output result_t pop_data
);

  result_t    slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign can_push  = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/remote_code_pulse_encoder_unit.sv
// Top level of the remote code pulse encoder.
// Depends on rcpe_pkg, rcpe_if, rcpe_cfg_regs, rcpe_core, rcpe_out_buf.
//
// Usage:
//   item   - valid/ready input. command=1 starts a frame with code_word (ignored
//            while a frame runs); command=0 is one base tick.
//   result - valid/ready output, one transaction per input transaction:
//            line_level, busy_res and frame_done for that item.
//   cfg    - register write channel (index 0..3: sync high, sync low, short,
//            long tick counts); always ready, write only while idle.
// A result is registered in the output buffer when its item is accepted.
// Throughput: one item per cycle while the buffer has room; the sequencer state
//   advances through short logic and the result lands in a two-entry output buffer.
// Stall: the buffer holds two results, so one more item is taken while a result
//   waits; item.ready drops only when both entries are full.
// Reset (rst, synchronous): line idle, no frame, buffer empty, timing registers
//   back to 1/31/1/3 ticks.
module remote_code_pulse_encoder_unit import rcpe_pkg::*; #(
  parameter int CODE_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  rcpe_item_if.sink     item,
  rcpe_result_if.source result,
  rcpe_cfg_if.sink      cfg
);

  timing_t timing;
  result_t core_result;
  result_t buf_data;
  logic    item_acc;
  logic    res_acc;
  logic    can_push;
  logic    busy;

  assign cfg.ready    = 1'b1;
  assign item.ready   = can_push;
  assign item_acc     = item.valid && item.ready;
  assign res_acc      = result.valid && result.ready;

  rcpe_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .timing   (timing)
  );

  rcpe_core #(.CODE_BITS(CODE_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (item_acc),
    .command   (item.command),
    .code_word (item.code_word),
    .timing    (timing),
    .result    (core_result),
    .busy      (busy)
  );

  rcpe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (item_acc),
    .push_data (core_result),
    .can_push  (can_push),
    .pop_valid (result.valid),
    .pop       (res_acc),
    .pop_data  (buf_data)
  );

  assign result.line_level = buf_data.line_level;
  assign result.busy_res   = buf_data.busy_res;
  assign result.frame_done = buf_data.frame_done;

  // Start accepted while idle must open a frame
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    item_acc && item.command && !busy |=> busy)
    else $error("start did not open a frame");

  // Frame end closes the sequencer
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    item_acc && core_result.frame_done |=> !busy)
    else $error("sequencer busy after frame_done");

  // Input stalls only when results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> result.valid)
    else $error("input stalled with no pending result");

  // Reset leaves the sequencer idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result.valid)
    else $error("not idle after reset");

endmodule
